[src/ati_pkg.sv]
// ----------------------------------------------------------------------------
// ati_pkg
// Shared types and constants of the attenuation table interpolator.
// ----------------------------------------------------------------------------
package ati_pkg;

  localparam int EnergyW = 16;
  localparam int CoefW   = 32;
  localparam int ScaledW = 40;
  localparam int DivW    = 17;

  localparam logic [1:0] StatExact  = 2'd0;
  localparam logic [1:0] StatInterp = 2'd1;
  localparam logic [1:0] StatEmpty  = 2'd2;
  localparam logic [1:0] StatNoBnd  = 2'd3;

  localparam logic [1:0] RegDensity = 2'd0;
  localparam logic [1:0] RegHalfBin = 2'd1;
  localparam logic [1:0] RegCount   = 2'd2;
  localparam logic [1:0] RegScale   = 2'd3;

  typedef struct packed {
    logic scan_start;
    logic scan_step;
    logic scale_start;
    logic mul_step;
    logic div_start;
    logic div_step;
    logic out_exact;
    logic out_interp;
    logic out_code;
  } ati_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic match;
    logic bounds_ok;
    logic div_last;
    logic mul_last;
  } ati_sts_t;

endpackage

[src/ati_datapath.sv]
// ----------------------------------------------------------------------------
// ati_datapath
// Table memory, bin test, bound tracking, shared multiplier and divider.
// ----------------------------------------------------------------------------
module ati_datapath import ati_pkg::*; #(
  parameter int TableDepth = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_en,
  input  logic [4:0]         load_index,
  input  logic [15:0]        load_energy,
  input  logic [31:0]        load_coef,
  input  logic               query_en,
  input  logic [15:0]        query_voltage,
  input  logic [15:0]        density,
  input  logic [15:0]        half_bin,
  input  logic [5:0]         entry_count,
  input  logic [15:0]        length_scale,
  input  ati_cmd_t           cmd,
  output ati_sts_t           sts,
  output logic               out_valid,
  output logic [31:0]        out_attenuation,
  output logic [1:0]         out_status
);

  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW = $clog2(TableDepth + 1);

  logic [EnergyW-1:0] energy_mem [TableDepth];
  logic [CoefW-1:0]   coef_mem   [TableDepth];
  logic [EnergyW-1:0] rd_energy_r;
  logic [CoefW-1:0]   rd_coef_r;

  logic [CntW-1:0]    idx_r, count_r;
  logic               rd_valid_r;
  logic signed [17:0] v_r, lower_r, upper_r;
  logic               lo_ok_r, hi_ok_r, match_r;
  logic [15:0]        lo_e_r, hi_e_r;
  logic [31:0]        lo_c_r, hi_c_r, m_c_r;

  // multiply/divide unit
  logic [2:0]         mstep_r;
  logic [ScaledW-1:0] a_r, b_r;
  logic [56:0]        diff_r;
  logic               neg_r;
  logic [73:0]        prod_r;
  logic [5:0]         dcnt_r;
  logic [73:0]        quo_r;
  logic [DivW:0]      rem_r;
  logic [DivW-1:0]    den_r;

  logic [CntW-1:0] count_lim;
  assign count_lim = ({26'd0, entry_count} > 32'(TableDepth)) ? CntW'(TableDepth)
                                                             : CntW'(entry_count);

  logic [IdxW-1:0] load_idx_w;
  assign load_idx_w = IdxW'(load_index);

  always_ff @(posedge clk) begin
    if (load_en && ({27'd0, load_index} < 32'(TableDepth))) begin
      energy_mem[load_idx_w] <= load_energy;
      coef_mem[load_idx_w]   <= load_coef;
    end
    rd_energy_r <= energy_mem[idx_r[IdxW-1:0]];
    rd_coef_r   <= coef_mem[idx_r[IdxW-1:0]];
  end

  logic signed [17:0] e_s;
  logic in_bin, below;
  assign e_s    = {2'b00, rd_energy_r};
  assign in_bin = (e_s >= lower_r) && (e_s <= upper_r);
  assign below  = e_s < lower_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      rd_valid_r <= 1'b0;
      match_r <= 1'b0;
      lo_ok_r <= 1'b0;
      hi_ok_r <= 1'b0;
    end else begin
      if (query_en) begin
        v_r     <= {2'b00, query_voltage};
        lower_r <= $signed({2'b00, query_voltage}) - $signed({2'b00, half_bin});
        upper_r <= $signed({2'b00, query_voltage}) + $signed({2'b00, half_bin});
        count_r <= count_lim;
      end
      if (cmd.scan_start) begin
        idx_r <= '0;
        rd_valid_r <= 1'b0;
        match_r <= 1'b0;
        lo_ok_r <= 1'b0;
        hi_ok_r <= 1'b0;
      end else if (cmd.scan_step) begin
        if (!rd_valid_r) begin
          rd_valid_r <= 1'b1;
          idx_r <= idx_r + 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
          if (in_bin && !match_r) begin
            match_r <= 1'b1;
            m_c_r <= rd_coef_r;
          end else if (below) begin
            if (!lo_ok_r || rd_energy_r >= lo_e_r) begin
              lo_ok_r <= 1'b1;
              lo_e_r <= rd_energy_r;
              lo_c_r <= rd_coef_r;
            end
          end else if (!hi_ok_r || rd_energy_r <= hi_e_r) begin
            hi_ok_r <= 1'b1;
            hi_e_r <= rd_energy_r;
            hi_c_r <= rd_coef_r;
          end
        end
      end
    end
  end

  // last compare happens when idx_r == count_r (entry count_r-1 in reg) or in_bin
  assign sts.scan_last = rd_valid_r && ((idx_r == count_r) || in_bin);
  assign sts.match     = match_r;
  assign sts.bounds_ok = lo_ok_r && hi_ok_r;

  // Shared sequence: step0..1 scale a (match or low), step2..3 scale b,
  // step4 diff, step5 diff*num.
  logic [31:0] mul_c;
  always_comb begin
    mul_c = match_r ? m_c_r : ((mstep_r < 3'd2) ? lo_c_r : hi_c_r);
  end

  logic [16:0] num_w;
  assign num_w = 17'(v_r - $signed({2'b00, lo_e_r}));
  logic [16:0] den_w;
  assign den_w = ({1'b0, hi_e_r} == {1'b0, lo_e_r}) ? 17'd1
               : 17'({1'b0, hi_e_r} - {1'b0, lo_e_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstep_r <= '0;
    end else if (cmd.scale_start) begin
      mstep_r <= '0;
    end else if (cmd.mul_step) begin
      mstep_r <= mstep_r + 1'b1;
      case (mstep_r)
        3'd0: prod_r <= 74'(mul_c) * 74'(density);
        3'd1: a_r <= ScaledW'((prod_r[47:0] * 64'(length_scale)) >> 24);
        3'd2: prod_r <= 74'(mul_c) * 74'(density);
        3'd3: begin
          b_r <= ScaledW'((prod_r[47:0] * 64'(length_scale)) >> 24);
        end
        3'd4: begin
          neg_r  <= b_r < a_r;
          diff_r <= 57'((b_r >= a_r) ? (b_r - a_r) : (a_r - b_r));
        end
        3'd5: prod_r <= 74'(diff_r) * 74'(num_w);
        default: ;
      endcase
    end
  end
  assign sts.mul_last = (mstep_r == 3'd6) || (match_r && mstep_r == 3'd2);

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= 6'd0;
      quo_r  <= {prod_r[56:0], 17'd0};
      rem_r  <= '0;
      den_r  <= den_w;
    end else if (cmd.div_step) begin
      logic [DivW+1:0] t;
      t = {rem_r, quo_r[73]};
      dcnt_r <= dcnt_r + 1'b1;
      if (t >= {2'b00, den_r}) begin
        rem_r <= (DivW+1)'(t - {2'b00, den_r});
        quo_r <= {quo_r[72:0], 1'b1};
      end else begin
        rem_r <= (DivW+1)'(t);
        quo_r <= {quo_r[72:0], 1'b0};
      end
    end
  end
  assign sts.div_last = dcnt_r == 6'd57;

  logic [ScaledW:0] res_w;
  always_comb begin
    if (neg_r) res_w = {1'b0, a_r} - (ScaledW+1)'(quo_r[56:0]);
    else       res_w = {1'b0, a_r} + (ScaledW+1)'(quo_r[56:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.out_exact || cmd.out_interp || cmd.out_code;
      if (cmd.out_exact) begin
        out_attenuation <= (a_r > 40'hFFFFFFFF) ? 32'hFFFFFFFF : a_r[31:0];
        out_status <= StatExact;
      end else if (cmd.out_interp) begin
        out_attenuation <= (res_w > 41'hFFFFFFFF) ? 32'hFFFFFFFF : res_w[31:0];
        out_status <= StatInterp;
      end else if (cmd.out_code) begin
        out_attenuation <= 32'd0;
        out_status <= query_en ? StatEmpty : StatNoBnd;
      end
    end
  end

endmodule

[src/ati_ctrl.sv]
// ----------------------------------------------------------------------------
// ati_ctrl
// Sequencer for scan, scaling, multiply and divide of one query.
// ----------------------------------------------------------------------------
module ati_ctrl import ati_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     query_en,
  input  logic     count_zero,
  input  ati_sts_t sts,
  output ati_cmd_t cmd,
  output logic     busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EVAL, S_MUL, S_DIV, S_DONE
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (query_en) state_r <= count_zero ? S_DONE : S_SCAN;
        S_SCAN: if (sts.scan_last) state_r <= S_EVAL;
        S_EVAL: state_r <= (sts.match || sts.bounds_ok) ? S_MUL : S_DONE;
        S_MUL:  if (sts.mul_last) state_r <= sts.match ? S_DONE : S_DIV;
        S_DIV:  if (sts.div_last) state_r <= S_DONE;
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.scan_start  = (state_r == S_IDLE) && query_en;
    cmd.scan_step   = (state_r == S_SCAN);
    cmd.scale_start = (state_r == S_SCAN);
    cmd.mul_step    = (state_r == S_MUL);
    cmd.div_start   = (state_r == S_MUL) && sts.mul_last;
    cmd.div_step    = (state_r == S_DIV);
    cmd.out_exact   = (state_r == S_MUL) && sts.mul_last && sts.match;
    cmd.out_interp  = (state_r == S_DIV) && sts.div_last;
    cmd.out_code    = ((state_r == S_IDLE) && query_en && count_zero)
                    || ((state_r == S_EVAL) && !sts.match && !sts.bounds_ok);
  end

  assign busy = state_r != S_IDLE;

endmodule

[src/attenuation_table_interpolator.sv]
// ----------------------------------------------------------------------------
// attenuation_table_interpolator
// Table lookup with linear interpolation of scaled attenuation.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. in_func 0 loads
//   table slot in_entry_index at that edge; busy stays low, so loads may
//   follow back to back. in_func 1 queries in_query_voltage; one result
//   follows on out_attenuation and out_status, marked by out_valid for one
//   cycle, and busy falls in the cycle after the result.
//   A query scans slots up to the first match or the last counted one. An
//   empty table or a missing bound gives a status code; a match is scaled;
//   else both bounds are scaled, their difference multiplied and divided.
//   Configuration is written through cfg_we, cfg_index, cfg_data while
//   idle; the block does not enforce this. Reset clears the registers to
//   their defaults; the table is undefined until loaded. The receiver
//   cannot stall: each result lasts one cycle.
// ----------------------------------------------------------------------------
module attenuation_table_interpolator import ati_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [4:0]  in_entry_index,
  input  logic [15:0] in_entry_energy,
  input  logic [31:0] in_entry_coefficient,
  input  logic [15:0] in_query_voltage,
  output logic        out_valid,
  output logic [31:0] out_attenuation,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] density_r, half_bin_r, length_scale_r;
  logic [5:0]  entry_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      density_r <= '0;
      half_bin_r <= '0;
      entry_count_r <= '0;
      length_scale_r <= 16'd6554;
    end else if (cfg_we) begin
      case (cfg_index)
        RegDensity: density_r <= cfg_data;
        RegHalfBin: half_bin_r <= cfg_data;
        RegCount:   entry_count_r <= cfg_data[5:0];
        RegScale:   length_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic accept, load_en, query_en;
  ati_cmd_t cmd;
  ati_sts_t sts;
  assign accept   = start && !busy;
  assign load_en  = accept && !in_func;
  assign query_en = accept && in_func;

  ati_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .query_en(query_en),
    .count_zero(entry_count_r == 6'd0), .sts(sts), .cmd(cmd), .busy(busy)
  );

  ati_datapath #(.TableDepth(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .load_en(load_en), .load_index(in_entry_index),
    .load_energy(in_entry_energy), .load_coef(in_entry_coefficient),
    .query_en(query_en), .query_voltage(in_query_voltage),
    .density(density_r), .half_bin(half_bin_r), .entry_count(entry_count_r),
    .length_scale(length_scale_r), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_attenuation(out_attenuation),
    .out_status(out_status)
  );

endmodule

[dv/attenuation_table_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attenuation_table_checker
// Watches the load/query and result channels, mirrors the table and the
// registers, predicts each query result and compares it field by field.
// ----------------------------------------------------------------------------
module attenuation_table_checker import ati_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_func,
  input  logic [4:0]  in_entry_index,
  input  logic [15:0] in_entry_energy,
  input  logic [31:0] in_entry_coefficient,
  input  logic [15:0] in_query_voltage,
  input  logic        out_valid,
  input  logic [31:0] out_attenuation,
  input  logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] atten;
    logic [1:0]  status;
  } lookup_t;

  logic [15:0] density_q, half_bin_q, scale_q;
  logic [5:0]  count_q;
  logic [15:0] energy_mem [32];
  logic [31:0] coef_mem [32];
  lookup_t     lookups_due [$];

  function automatic longint unsigned scaled(logic [31:0] c);
    longint unsigned p;
    p = longint'(c) * longint'(density_q);
    p = p * longint'(scale_q);
    return p >> 24;
  endfunction

  function automatic logic [31:0] sat(longint unsigned x);
    return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  function automatic lookup_t lookup(logic [15:0] volt);
    lookup_t r;
    int v, lo, hi, n, e, lo_e, hi_e;
    bit lo_ok, hi_ok;
    longint unsigned s, lo_c, hi_c, num, den;
    v = volt;
    lo = v - int'(half_bin_q);
    hi = v + int'(half_bin_q);
    n = (count_q > 32) ? 32 : count_q;
    lo_ok = 0; hi_ok = 0; lo_e = 0; hi_e = 0; lo_c = 0; hi_c = 0;
    if (n == 0) begin
      r.atten = '0;
      r.status = StatEmpty;
      return r;
    end
    for (int i = 0; i < n; i++) begin
      e = energy_mem[i];
      s = scaled(coef_mem[i]);
      if (e >= lo && e <= hi) begin
        r.atten = sat(s);
        r.status = StatExact;
        return r;
      end
      if (e < lo) begin
        if (!lo_ok || e >= lo_e) begin
          lo_ok = 1; lo_e = e; lo_c = s;
        end
      end else if (!hi_ok || e <= hi_e) begin
        hi_ok = 1; hi_e = e; hi_c = s;
      end
    end
    if (!lo_ok || !hi_ok) begin
      r.atten = '0;
      r.status = StatNoBnd;
      return r;
    end
    num = longint'(v - lo_e);
    den = longint'(hi_e - lo_e);
    if (den == 0) den = 1;
    if (hi_c >= lo_c) r.atten = sat(lo_c + ((hi_c - lo_c) * num) / den);
    else r.atten = sat(lo_c - ((lo_c - hi_c) * num) / den);
    r.status = StatInterp;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t got, want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      density_q <= '0;
      half_bin_q <= '0;
      count_q <= '0;
      scale_q <= 16'd6554;
      errors <= 0;
      pending <= 0;
      lookups_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegDensity: density_q <= cfg_data;
          RegHalfBin: half_bin_q <= cfg_data;
          RegCount:   count_q <= cfg_data[5:0];
          RegScale:   scale_q <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (!in_func) begin
          energy_mem[in_entry_index] <= in_entry_energy;
          coef_mem[in_entry_index] <= in_entry_coefficient;
        end else begin
          lookups_due.push_back(lookup(in_query_voltage));
        end
      end
      if (out_valid) begin
        got.atten = out_attenuation;
        got.status = out_status;
        if (lookups_due.size() == 0) begin
          $display("%0t: unexpected result exp none act %h/%0d", $time,
                   got.atten, got.status);
          bad = bad + 1;
        end else begin
          want = lookups_due.pop_front();
          if (got.atten !== want.atten) begin
            $display("%0t: attenuation exp %h act %h", $time, want.atten, got.atten);
            bad = bad + 1;
          end
          if (got.status !== want.status) begin
            $display("%0t: status exp %0d act %0d", $time, want.status, got.status);
            bad = bad + 1;
          end
        end
      end
      errors <= errors + bad;
      pending <= lookups_due.size();
    end
  end

endmodule

[dv/attenuation_table_interpolator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attenuation_table_interpolator_test
// Loads the table, runs directed lookups (exact, interpolated, empty, bound
// missing, ties, saturation, register extremes) and then random phases under
// several register settings and sender gap rates.
// ----------------------------------------------------------------------------
module attenuation_table_interpolator_test import ati_pkg::*; ();

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_func;
  logic [4:0]  in_entry_index;
  logic [15:0] in_entry_energy;
  logic [31:0] in_entry_coefficient;
  logic [15:0] in_query_voltage;
  logic        out_valid;
  logic [31:0] out_attenuation;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;
  int          gap_pct;
  int          quiet_cycles;
  logic [15:0] energy_copy [32];

  attenuation_table_interpolator dut (.*);
  attenuation_table_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic transfer(logic f, logic [4:0] idx, logic [15:0] e, logic [31:0] c,
                          logic [15:0] v);
    while ($urandom_range(99) < gap_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_func <= f;
    in_entry_index <= idx;
    in_entry_energy <= e;
    in_entry_coefficient <= c;
    in_query_voltage <= v;
    if (!f) energy_copy[idx] = e;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic load(logic [4:0] idx, logic [15:0] e, logic [31:0] c);
    transfer(1'b0, idx, e, c, 16'($urandom));
  endtask

  task automatic query(logic [15:0] v);
    transfer(1'b1, 5'($urandom), 16'($urandom), $urandom, v);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_regs(logic [15:0] dens, logic [15:0] hb, logic [15:0] cnt,
                          logic [15:0] scl);
    drain();
    write_reg(RegDensity, dens);
    write_reg(RegHalfBin, hb);
    write_reg(RegCount, cnt);
    write_reg(RegScale, scl);
  endtask

  initial begin
    logic [15:0] v;
    rst_n = 0;
    start = 0;
    in_func = 0;
    in_entry_index = 0;
    in_entry_energy = 0;
    in_entry_coefficient = 0;
    in_query_voltage = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    gap_pct = 8;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty table at reset defaults
    query(16'd100);
    query(16'hFFFF);
    for (int i = 0; i < 32; i++)
      load(5'(i), 16'(i * 512 + 256), 32'h0001_0000 * (i + 1));
    load(5'd31, 16'hFFFF, 32'hFFFF_FFFF);
    load(5'd0, 16'h0000, 32'h0000_0000);
    load(5'd5, 16'd1280, 32'h0050_0000);  // tie with slot 2's energy
    set_regs(16'h0100, 16'd0, 16'd32, 16'hFFFF);
    query(16'd256 * 3);                    // exact
    query(16'd1000);                       // interpolated
    query(16'd1280);                       // exact on a duplicate energy
    query(16'd1100);                       // interpolate across the tie
    query(16'h0000);                       // exact at lowest
    query(16'hFFFF);                       // exact at highest
    set_regs(16'hFFFF, 16'd0, 16'd63, 16'hFFFF);
    query(16'hFFFF);                       // saturation, count clamps
    query(16'd700);
    set_regs(16'h0100, 16'd0, 16'd4, 16'd6554);
    query(16'd60000);                      // no upper bound
    set_regs(16'h0100, 16'd0, 16'd1, 16'd0);
    query(16'd5);                          // no bound above
    set_regs(16'h0100, 16'hFFFF, 16'd32, 16'd6554);
    query(16'd12345);                      // wide bin, first entry
    set_regs(16'h0000, 16'd3, 16'd20, 16'd6554);
    query(16'd5000);

    for (int ph = 0; ph < 6; ph++) begin
      gap_pct = (ph < 2) ? 8 : (ph < 4) ? 73 : 0;
      case (ph)
        0: set_regs(16'hFFFF, 16'd0, 16'd32, 16'hFFFF);
        1: set_regs(16'($urandom), 16'($urandom_range(0, 31)), 16'($urandom_range(1, 32)),
                    16'd6554);
        2: set_regs(16'($urandom), 16'($urandom_range(0, 255)), 16'd63, 16'($urandom));
        3: set_regs(16'h0000, 16'($urandom), 16'($urandom_range(0, 63)), 16'h0000);
        4: set_regs(16'($urandom), 16'hFFFF, 16'd32, 16'($urandom));
        default: set_regs(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 15)),
                          16'($urandom_range(2, 32)), 16'($urandom));
      endcase
      for (int n = 0; n < 250; n++) begin
        if (n == 125 && ph == 1) drain();
        if ($urandom_range(3) == 0) begin
          load(5'($urandom), ($urandom_range(3) == 0) ? 16'($urandom)
               : 16'($urandom_range(0, 4095)), $urandom);
        end else begin
          if ($urandom_range(4) == 0)
            v = energy_copy[$urandom_range(0, 31)] + 16'($urandom_range(0, 4)) - 16'd2;
          else if ($urandom_range(2) == 0) v = 16'($urandom);
          else v = 16'($urandom_range(0, 4095));
          query(v);
        end
      end
    end

    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
